// ----- rtl/core/rtp_pkg.sv -----
// Shared constants and register codes for the Planck raw-to-temperature block.
`timescale 1ns / 1ps
package rtp_pkg;

  localparam int CFG_DW = 40;
  localparam int CFG_IW = 3;

  localparam logic [CFG_IW-1:0] REG_R1      = 3'd0;
  localparam logic [CFG_IW-1:0] REG_R2      = 3'd1;
  localparam logic [CFG_IW-1:0] REG_B       = 3'd2;
  localparam logic [CFG_IW-1:0] REG_F       = 3'd3;
  localparam logic [CFG_IW-1:0] REG_O       = 3'd4;
  localparam logic [CFG_IW-1:0] REG_RAW_MIN = 3'd5;
  localparam logic [CFG_IW-1:0] REG_RAW_MAX = 3'd6;

  localparam logic [31:0]        R1_RST      = 32'd1089707622;
  localparam logic [39:0]        R2_RST      = 40'd16048646016;
  localparam logic [23:0]        B_RST       = 24'd1463603;
  localparam logic [19:0]        F_RST       = 20'd1024;
  localparam logic signed [20:0] O_RST       = -21'sd70720;
  localparam logic signed [24:0] RAW_MIN_RST = 25'sd228630;
  localparam logic signed [24:0] RAW_MAX_RST = 25'sd240066;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [63:0] LOG_ONE = 64'h0000_0001_0000_0000;

  localparam int TW = 20;
  localparam logic signed [TW-1:0] TEMP_LOW   = -20'sd27315;
  localparam logic signed [TW-1:0] TEMP_HIGH  = 20'sd500000;
  localparam logic [TW-1:0]        C_OFFSET   = 20'd27315;
  localparam logic [TW-1:0]        KELVIN_MAX = 20'd527315;

endpackage

// ----- rtl/core/rtp_div_cell.sv -----
// One restoring division step: shift in a dividend bit, compare, subtract.
`timescale 1ns / 1ps
module rtp_div_cell #(
  parameter int RW = 8,
  parameter int NB = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rem_i,
  input  logic [RW-1:0] den_i,
  input  logic [NB-1:0] dvd_i,
  input  logic [NB-1:0] quo_i,
  input  logic [SW-1:0] side_i,
  output logic [RW-1:0] rem_o,
  output logic [RW-1:0] den_o,
  output logic [NB-1:0] dvd_o,
  output logic [NB-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          ge;
  logic [RW-1:0] rem_nxt;
  logic [NB-1:0] dvd_nxt;
  logic [NB-1:0] quo_nxt;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] den_r;
  logic [NB-1:0] dvd_r;
  logic [NB-1:0] quo_r;
  logic [SW-1:0] side_r;

  always_comb begin
    trial   = {rem_i, dvd_i[NB-1]};
    diff    = trial - {1'b0, den_i};
    ge      = trial >= {1'b0, den_i};
    rem_nxt = ge ? diff[RW-1:0] : trial[RW-1:0];
    dvd_nxt = {dvd_i[NB-2:0], 1'b0};
    quo_nxt = {quo_i[NB-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      den_r  <= den_i;
      dvd_r  <= dvd_nxt;
      quo_r  <= quo_nxt;
      side_r <= side_i;
    end
  end

  assign rem_o  = rem_r;
  assign den_o  = den_r;
  assign dvd_o  = dvd_r;
  assign quo_o  = quo_r;
  assign side_o = side_r;

endmodule

// ----- rtl/core/rtp_norm_cell.sv -----
// One leading-one normalization step: shift left by SH if the top SH bits are zero.
`timescale 1ns / 1ps
module rtp_norm_cell #(
  parameter int SH = 1,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [63:0]   a_i,
  input  logic [5:0]    z_i,
  input  logic [SW-1:0] side_i,
  output logic [63:0]   a_o,
  output logic [5:0]    z_o,
  output logic [SW-1:0] side_o
);

  logic        zero;
  logic [63:0] a_nxt;
  logic [5:0]  z_nxt;
  logic [63:0] a_r;
  logic [5:0]  z_r;
  logic [SW-1:0] side_r;

  always_comb begin
    zero  = a_i[63 -: SH] == '0;
    a_nxt = zero ? (a_i << SH) : a_i;
    z_nxt = zero ? (z_i + 6'(SH)) : z_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a_nxt;
      z_r    <= z_nxt;
      side_r <= side_i;
    end
  end

  assign a_o    = a_r;
  assign z_o    = z_r;
  assign side_o = side_r;

endmodule

// ----- rtl/core/rtp_log_cell.sv -----
// One log2 fraction bit: square the Q31 mantissa and renormalize.
`timescale 1ns / 1ps
module rtp_log_cell #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [31:0]   m_i,
  input  logic [31:0]   frac_i,
  input  logic [SW-1:0] side_i,
  output logic [31:0]   m_o,
  output logic [31:0]   frac_o,
  output logic [SW-1:0] side_o
);

  logic [63:0] sq;
  logic [32:0] t;
  logic [31:0] m_nxt;
  logic [31:0] frac_nxt;
  logic [31:0] m_r;
  logic [31:0] frac_r;
  logic [SW-1:0] side_r;

  always_comb begin
    sq       = 64'(m_i) * 64'(m_i);
    t        = sq[63:31];
    m_nxt    = t[32] ? t[32:1] : t[31:0];
    frac_nxt = {frac_i[30:0], t[32]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= m_nxt;
      frac_r <= frac_nxt;
      side_r <= side_i;
    end
  end

  assign m_o    = m_r;
  assign frac_o = frac_r;
  assign side_o = side_r;

endmodule

// ----- rtl/core/raw_to_temperature_planck.sv -----
// Top level: thermal pixel to centi-degrees Celsius by the inverse Planck relation.
//
// Input channel in_valid/in_ready carries one pixel intensity per transfer; only the
// low PIXEL_BITS bits are used. Output channel out_valid/out_ready carries the
// temperature in hundredths of a degree Celsius and an invalid flag, one result per
// pixel, in order.
// Throughput is one pixel per clock while the receiver does not stall. Each pixel passes
// through the 64-step quotient row, the 6-step normalizer, the 32-step log2 row of
// squaring cells and the 20-step kelvin quotient row, plus the mapping, multiply
// and fix-up stages.
// When the receiver stalls, the whole row of cells holds; the first stage still
// takes one more pixel if it is empty.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// Planck constants. The cfg_we/cfg_index/cfg_wdata port writes one register per
// clock; write only while no pixel is in flight. Indexes beyond 6 are ignored.
`timescale 1ns / 1ps
module raw_to_temperature_planck #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [15:0]                 in_pixel_intensity,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rtp_pkg::TW-1:0]      out_temperature_centi,
  output logic                        out_invalid,
  input  logic                        cfg_we,
  input  logic [rtp_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [rtp_pkg::CFG_DW-1:0]  cfg_wdata
);

  import rtp_pkg::*;

  localparam int MW = PIXEL_BITS + 1;
  localparam int PW = 27 + PIXEL_BITS;
  localparam int XM = 26 + PIXEL_BITS;
  localparam int XH = XM - 21;
  localparam int DW = 66 + PIXEL_BITS;
  localparam int NW = 32 + PIXEL_BITS;
  localparam int D1 = 64;
  localparam int NRM = 6;
  localparam int LGB = 32;
  localparam int D2 = 20;
  localparam int KW = 37;
  localparam int NS = 6 + D1 + 1 + NRM + LGB + 3 + D2;
  localparam logic [MW-1:0] MVAL = MW'((1 << PIXEL_BITS) - 1);

  logic [31:0]        r1_r;
  logic [39:0]        r2_r;
  logic [23:0]        b_r;
  logic [19:0]        f_r;
  logic signed [20:0] o_r;
  logic signed [24:0] mn_r;
  logic signed [24:0] mx_r;

  logic          adv;
  logic          ld0;
  logic [NS-1:0] vld_r;
  logic          out_valid_r;
  logic [TW-1:0] temp_r;
  logic          inv_r;
  logic [TW-1:0] temp_nxt;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_r <= R1_RST;
      r2_r <= R2_RST;
      b_r  <= B_RST;
      f_r  <= F_RST;
      o_r  <= O_RST;
      mn_r <= RAW_MIN_RST;
      mx_r <= RAW_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_R1:      r1_r <= cfg_wdata[31:0];
        REG_R2:      r2_r <= cfg_wdata[39:0];
        REG_B:       b_r  <= cfg_wdata[23:0];
        REG_F:       f_r  <= cfg_wdata[19:0];
        REG_O:       o_r  <= cfg_wdata[20:0];
        REG_RAW_MIN: mn_r <= cfg_wdata[24:0];
        REG_RAW_MAX: mx_r <= cfg_wdata[24:0];
        default: ;
      endcase
    end
  end

  // flow control
  assign adv      = !out_valid_r || out_ready;
  assign ld0      = adv || !vld_r[0];
  assign in_ready = ld0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld0) vld_r[0] <= in_valid;
      if (adv) begin
        vld_r[NS-1:1] <= vld_r[NS-2:0];
        out_valid_r   <= vld_r[NS-1];
      end
    end
  end

  // stage 0: pixel
  logic [PIXEL_BITS-1:0] p_r;
  always_ff @(posedge clk) begin
    if (ld0) p_r <= in_pixel_intensity[PIXEL_BITS-1:0];
  end

  // stages 1..4: linear map, raw + O, denominator and numerator products
  logic signed [25:0]   mo;
  logic signed [25:0]   dm;
  logic signed [PW-1:0] pa_nxt;
  logic signed [PW-1:0] pb_nxt;
  logic signed [PW-1:0] pa_r;
  logic signed [PW-1:0] pb_r;
  logic signed [PW-1:0] x_r;
  logic                 bad3_nxt;
  logic [XM-1:0]        xm;
  logic                 bad3_r;
  logic [60:0]          dlo_r;
  logic [40+XH-1:0]     dhi_r;
  logic [NW-1:0]        num3_r;
  logic [DW-1:0]        d_r;
  logic [NW-1:0]        num4_r;
  logic                 bad4_r;

  always_comb begin
    mo       = 26'(mn_r) + 26'(o_r);
    dm       = 26'(mx_r) - 26'(mn_r);
    pa_nxt   = PW'(mo) * PW'($signed(MVAL));
    pb_nxt   = PW'(dm) * PW'($signed({1'b0, p_r}));
    bad3_nxt = (r2_r == '0) || x_r[PW-1] || (x_r == '0);
    xm       = x_r[XM-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r   <= pa_nxt;
      pb_r   <= pb_nxt;
      x_r    <= pa_r + pb_r;
      bad3_r <= bad3_nxt;
      dlo_r  <= 61'(r2_r) * 61'(xm[20:0]);
      dhi_r  <= (40 + XH)'(r2_r) * (40 + XH)'(xm[XM-1:21]);
      num3_r <= NW'(r1_r) * NW'(MVAL);
      d_r    <= DW'(dlo_r) + (DW'(dhi_r) << 21);
      num4_r <= num3_r;
      bad4_r <= bad3_r;
    end
  end

  // stage 5: quotient saturation check, then 64 quotient cells
  logic [DW-1:0] c1_rem  [0:D1];
  logic [DW-1:0] c1_den  [0:D1];
  logic [63:0]   c1_dvd  [0:D1];
  logic [63:0]   c1_quo  [0:D1];
  logic [1:0]    c1_side [0:D1];
  logic [DW-1:0] hi5;

  assign hi5 = DW'(num4_r[NW-1:4]);

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_rem[0]  <= hi5;
      c1_den[0]  <= d_r;
      c1_dvd[0]  <= {num4_r[3:0], 60'd0};
      c1_quo[0]  <= '0;
      c1_side[0] <= {bad4_r, hi5 >= d_r};
    end
  end

  for (genvar gi = 0; gi < D1; gi++) begin : g_div1
    rtp_div_cell #(.RW(DW), .NB(64), .SW(2)) u_cell (
      .clk    (clk),
      .en     (adv),
      .rem_i  (c1_rem[gi]),
      .den_i  (c1_den[gi]),
      .dvd_i  (c1_dvd[gi]),
      .quo_i  (c1_quo[gi]),
      .side_i (c1_side[gi]),
      .rem_o  (c1_rem[gi+1]),
      .den_o  (c1_den[gi+1]),
      .dvd_o  (c1_dvd[gi+1]),
      .quo_o  (c1_quo[gi+1]),
      .side_o (c1_side[gi+1])
    );
  end

  // stage 70: add F, saturate, log argument check
  logic [64:0] asum;
  logic [63:0] a_nxt;
  logic [63:0] n_a  [0:NRM];
  logic [5:0]  n_z  [0:NRM];
  logic        n_bad[0:NRM];

  always_comb begin
    asum  = {1'b0, c1_quo[D1]} + (65'(f_r) << 22);
    a_nxt = (c1_side[D1][0] || asum[64]) ? '1 : asum[63:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_a[0]   <= a_nxt;
      n_z[0]   <= '0;
      n_bad[0] <= c1_side[D1][1] || (a_nxt <= LOG_ONE);
    end
  end

  for (genvar gi = 0; gi < NRM; gi++) begin : g_norm
    rtp_norm_cell #(.SH(32 >> gi), .SW(1)) u_cell (
      .clk    (clk),
      .en     (adv),
      .a_i    (n_a[gi]),
      .z_i    (n_z[gi]),
      .side_i (n_bad[gi]),
      .a_o    (n_a[gi+1]),
      .z_o    (n_z[gi+1]),
      .side_o (n_bad[gi+1])
    );
  end

  // log2 fraction: 32 squaring cells; side carries {bad, integer part}
  logic [31:0] lg_m   [0:LGB];
  logic [31:0] lg_frac[0:LGB];
  logic [5:0]  lg_side[0:LGB];
  logic [5:0]  zi;

  assign zi         = 6'd31 - n_z[NRM];
  assign lg_m[0]    = n_a[NRM][63:32];
  assign lg_frac[0] = '0;
  assign lg_side[0] = {n_bad[NRM], zi[4:0]};

  for (genvar gi = 0; gi < LGB; gi++) begin : g_log
    rtp_log_cell #(.SW(6)) u_cell (
      .clk    (clk),
      .en     (adv),
      .m_i    (lg_m[gi]),
      .frac_i (lg_frac[gi]),
      .side_i (lg_side[gi]),
      .m_o    (lg_m[gi+1]),
      .frac_o (lg_frac[gi+1]),
      .side_o (lg_side[gi+1])
    );
  end

  // ln = log2 * ln2, then kelvin numerator
  logic [63:0]   pf_r;
  logic [KW-1:0] pi_r;
  logic [30:0]   bh_r;
  logic          bad9_r;
  logic [KW-1:0] ln_nxt;
  logic [53:0]   n2_nxt;
  logic [KW-1:0] ln_r;
  logic [53:0]   n2_r;
  logic          bad10_r;
  logic [KW-1:0] hi11;

  always_comb begin
    ln_nxt = pi_r + KW'(pf_r[63:32]);
    n2_nxt = 54'({bh_r, 22'd0}) + 54'(ln_nxt[KW-1:1]);
    hi11   = KW'(n2_r[53:20]);
  end

  logic [KW-1:0] c2_rem  [0:D2];
  logic [KW-1:0] c2_den  [0:D2];
  logic [D2-1:0] c2_dvd  [0:D2];
  logic [D2-1:0] c2_quo  [0:D2];
  logic [1:0]    c2_side [0:D2];

  always_ff @(posedge clk) begin
    if (adv) begin
      pf_r       <= 64'(lg_frac[LGB]) * 64'(LN2_Q32);
      pi_r       <= KW'(lg_side[LGB][4:0]) * KW'(LN2_Q32);
      bh_r       <= 31'(b_r) * 31'(100);
      bad9_r     <= lg_side[LGB][5];
      ln_r       <= ln_nxt;
      n2_r       <= n2_nxt;
      bad10_r    <= bad9_r;
      c2_rem[0]  <= hi11;
      c2_den[0]  <= ln_r;
      c2_dvd[0]  <= n2_r[D2-1:0];
      c2_quo[0]  <= '0;
      c2_side[0] <= {bad10_r, hi11 >= ln_r};
    end
  end

  for (genvar gi = 0; gi < D2; gi++) begin : g_div2
    rtp_div_cell #(.RW(KW), .NB(D2), .SW(2)) u_cell (
      .clk    (clk),
      .en     (adv),
      .rem_i  (c2_rem[gi]),
      .den_i  (c2_den[gi]),
      .dvd_i  (c2_dvd[gi]),
      .quo_i  (c2_quo[gi]),
      .side_i (c2_side[gi]),
      .rem_o  (c2_rem[gi+1]),
      .den_o  (c2_den[gi+1]),
      .dvd_o  (c2_dvd[gi+1]),
      .quo_o  (c2_quo[gi+1]),
      .side_o (c2_side[gi+1])
    );
  end

  // result fix-up and output register
  always_comb begin
    if (c2_side[D2][1]) begin
      temp_nxt = TEMP_LOW;
    end else if (c2_side[D2][0] || (c2_quo[D2] > KELVIN_MAX)) begin
      temp_nxt = TEMP_HIGH;
    end else begin
      temp_nxt = c2_quo[D2] - C_OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      temp_r <= temp_nxt;
      inv_r  <= c2_side[D2][1];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = temp_r;
  assign out_invalid           = inv_r;

  a_invalid_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> $signed(out_temperature_centi) == TEMP_LOW)
    else $error("invalid result not saturated low");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_invalid |->
      $signed(out_temperature_centi) >= TEMP_LOW &&
      $signed(out_temperature_centi) <= TEMP_HIGH)
    else $error("temperature out of range");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without output stall");

endmodule

// ----- tb/tb.sv -----
// Testbench for the Planck raw-to-temperature pipeline: random and directed pixels, scoreboard check.
`timescale 1ns / 1ps
module tb;
  import rtp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_pixel_intensity = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [TW-1:0] out_temperature_centi;
  logic out_invalid;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  int unsigned s_idle = 0;
  int unsigned r_idle = 0;
  bit hold_req = 0;
  int unsigned hold_cnt = 0;
  int unsigned cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  raw_to_temperature_planck dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel_intensity(in_pixel_intensity),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_temperature_centi(out_temperature_centi), .out_invalid(out_invalid),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    logic [TW-1:0] temp;
    logic          inv;
  } temp_result_t;

  class temp_scoreboard;
    logic [31:0] r1;
    logic [39:0] r2;
    logic [23:0] b;
    logic [19:0] f;
    logic signed [20:0] o;
    logic signed [24:0] raw_min;
    logic signed [24:0] raw_max;
    temp_result_t pending[$];
    int errors;

    function new();
      r1 = R1_RST; r2 = R2_RST; b = B_RST; f = F_RST;
      o = O_RST; raw_min = RAW_MIN_RST; raw_max = RAW_MAX_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_R1: r1 = val[31:0];
        REG_R2: r2 = val[39:0];
        REG_B: b = val[23:0];
        REG_F: f = val[19:0];
        REG_O: o = val[20:0];
        REG_RAW_MIN: raw_min = val[24:0];
        REG_RAW_MAX: raw_max = val[24:0];
        default: ;
      endcase
    endfunction

    function temp_result_t planck_temp(logic [15:0] p);
      temp_result_t res;
      longint x, temp;
      logic [63:0] xu, qs, a, m, l, ln, num, kk;
      logic [127:0] n, d, q, prod;
      logic [31:0] frac;
      int k;
      res.inv = 1'b0;
      x = (longint'(raw_min) + longint'(o)) * 65535
        + (longint'(raw_max) - longint'(raw_min)) * longint'(p);
      if (r2 == 0 || x <= 0) begin
        res.inv = 1'b1;
        temp = longint'(TEMP_LOW);
      end else begin
        xu = x;
        n = (128'(r1) * 128'd65535) << 60;
        d = 128'(r2) * 128'(xu);
        q = n / d;
        qs = (q[127:64] != 0) ? '1 : q[63:0];
        a = qs + (64'(f) << 22);
        if (a < qs) a = '1;
        if (a <= LOG_ONE) begin
          res.inv = 1'b1;
          temp = longint'(TEMP_LOW);
        end else begin
          k = 63;
          while (k > 0 && !a[k]) k--;
          m = a >> (k - 31);
          frac = '0;
          for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
              m = m >> 1;
              frac[31-i] = 1'b1;
            end
          end
          l = {32'(k - 32), frac};
          prod = 128'(l) * 128'(LN2_Q32);
          ln = prod[95:32];
          if (ln == 0) begin
            temp = longint'(TEMP_HIGH);
          end else begin
            num = (64'(b) * 64'd100) << 22;
            kk = (num + (ln >> 1)) / ln;
            if (kk > 64'(KELVIN_MAX)) temp = longint'(TEMP_HIGH);
            else temp = longint'(kk) - longint'(C_OFFSET);
          end
        end
      end
      res.temp = temp[TW-1:0];
      return res;
    endfunction

    function void add_pixel(logic [15:0] p);
      pending.push_back(planck_temp(p));
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at cycle %0d: %s", cycles, what);
      errors++;
    endtask

    task check_result(logic [TW-1:0] t, logic inv);
      temp_result_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result temp=%0d inv=%0b", $signed(t), inv));
      end else begin
        e = pending.pop_front();
        if (t !== e.temp)
          report_mismatch($sformatf("temp got %0d want %0d", $signed(t), $signed(e.temp)));
        if (inv !== e.inv)
          report_mismatch($sformatf("invalid got %0b want %0b", inv, e.inv));
      end
    endtask
  endclass

  temp_scoreboard sb = new();

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 300000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.add_pixel(in_pixel_intensity);
    if (rst_n && out_valid && out_ready) sb.check_result(out_temperature_centi, out_invalid);
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= r_idle);
    end
  end

  task cfg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task send_pixel(logic [15:0] p);
    while ($urandom_range(99) < s_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_intensity <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task set_all(logic [31:0] r1, logic [39:0] r2, logic [23:0] b, logic [19:0] f,
               logic [20:0] o, logic [24:0] rmin, logic [24:0] rmax);
    cfg_write(REG_R1, 40'(r1));
    cfg_write(REG_R2, r2);
    cfg_write(REG_B, 40'(b));
    cfg_write(REG_F, 40'(f));
    cfg_write(REG_O, 40'(o));
    cfg_write(REG_RAW_MIN, 40'(rmin));
    cfg_write(REG_RAW_MAX, 40'(rmax));
  endtask

  task send_extremes();
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'h5555);
    send_pixel(16'hAAAA);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults after reset
    send_extremes();
    drain();
    // r2 of zero: no divisor
    cfg_write(REG_R2, '0);
    cfg_write(3'd7, '1);
    send_pixel(16'h1234);
    send_pixel(16'hFFFF);
    drain();
    // raw plus offset not positive
    set_all(R1_RST, R2_RST, B_RST, F_RST, 21'h100000, RAW_MIN_RST, RAW_MIN_RST);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    drain();
    // log argument not above one
    set_all(32'd0, R2_RST, B_RST, F_RST, O_RST, RAW_MIN_RST, RAW_MAX_RST);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    drain();
    // tiny quotient on top of one, log argument exactly one
    set_all(32'd1, 40'hFF_FFFF_FFFF, 24'hFFFFFF, F_RST, 21'h0FFFFF, 25'h0FFFFFF, 25'h0FFFFFF);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    drain();
    // saturating quotient: maximal R1, B and F, R2 of one
    set_all(32'hFFFF_FFFF, 40'd1, 24'hFFFFFF, 20'hFFFFF, 21'd1, 25'd0, 25'h0FFFFFF);
    send_extremes();
    drain();
    set_all(32'hFFFF_FFFF, 40'd1, 24'd0, 20'd0, 21'd0, 25'h1000000, 25'h0FFFFFF);
    send_extremes();
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin s_idle = 9; r_idle = 76; end
      else if (ph < 8) begin s_idle = 76; r_idle = 9; end
      else begin s_idle = 0; r_idle = 0; end
      if (ph % 3 != 2)
        set_all(32'(R1_RST + $urandom_range(0, 1 << 26) - (1 << 25)),
                R2_RST + {8'd0, $urandom_range(0, 1 << 30)} - 40'd536870912,
                24'(B_RST + $urandom_range(0, 1 << 18) - (1 << 17)),
                20'($urandom_range(1024, 2047)),
                21'(O_RST + $urandom_range(0, 40000) - 20000),
                25'(RAW_MIN_RST + $urandom_range(0, 40000) - 20000),
                25'(RAW_MAX_RST + $urandom_range(0, 40000) - 20000));
      else
        set_all($urandom, {8'($urandom), 32'($urandom)}, 24'($urandom), 20'($urandom),
                21'($urandom), 25'($urandom), 25'($urandom));
      for (int i = 0; i < ((ph == 9) ? 240 : 90); i++) begin
        if (ph == 9 && i == 10) hold_req = 1;
        if (ph == 10 && i == 50) begin
          in_valid <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
        send_pixel(16'($urandom));
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
